/* rtl/kvrp_pkg.sv */
`timescale 1ns / 1ps

package kvrp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned VALUE_W = 32;

  localparam logic [ID_W-1:0] ID_OFFSET = 5'd15;

  // Number conversion phases
  localparam logic [1:0] NUM_SKIP   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_STOP   = 2'd2;

  typedef struct packed {
    logic [1:0]         phase;
    logic               negative;
    logic [VALUE_W-1:0] acc;
  } num_state_t;

  // Name ROM: text right-justified, first character in the highest used byte
  localparam int unsigned ROM_SLOTS = 32;
  localparam int unsigned NAME_CHARS = 16;
  localparam int unsigned NAME_BITS = NAME_CHARS * 8;

  localparam logic [NAME_BITS-1:0] ROM_NAME [ROM_SLOTS] = '{
    0:  "TIME",
    1:  "WATT",
    2:  "ENERGYDAY",
    3:  "ENRGDAYSUM",
    4:  "ENERGYMON",
    5:  "ENRGMONSUM",
    6:  "WATTMONMAX",
    7:  "WGAINA",
    8:  "WGAINN",
    9:  "WGAINN",
    10: "WGAINN",
    11: "WATTINTERVAL",
    12: "WATTMAX",
    13: "CURMAX",
    14: "VOLTMAX",
    default: '0
  };

  localparam logic [4:0] ROM_LEN [ROM_SLOTS] = '{
    0:  5'd4,
    1:  5'd4,
    2:  5'd9,
    3:  5'd10,
    4:  5'd9,
    5:  5'd10,
    6:  5'd10,
    7:  5'd6,
    8:  5'd6,
    9:  5'd6,
    10: 5'd6,
    11: 5'd12,
    12: 5'd7,
    13: 5'd6,
    14: 5'd7,
    default: 5'd0
  };

  // Character at position pos of a name; only meaningful for pos < length
  function automatic logic [7:0] rom_char(logic [4:0] slot, logic [3:0] pos);
    logic [NAME_BITS-1:0] name;
    logic [3:0]           idx;
    logic [6:0]           base;
    name = ROM_NAME[slot];
    idx  = 4'(ROM_LEN[slot] - 5'(pos) - 5'd1);
    base = {idx, 3'b000};
    return name[base +: 8];
  endfunction

endpackage

/* rtl/kvrp_in_if.sv */
`timescale 1ns / 1ps

interface kvrp_in_if;
  logic                          valid;
  logic                          ready;
  logic [kvrp_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/kvrp_out_if.sv */
`timescale 1ns / 1ps

interface kvrp_out_if;
  logic                          valid;
  logic                          ready;
  logic [kvrp_pkg::ID_W-1:0]     param_id;
  logic [kvrp_pkg::VALUE_W-1:0]  param_value;

  modport source (output valid, output param_id, output param_value, input ready);
  modport sink   (input valid, input param_id, input param_value, output ready);
endinterface

/* rtl/kvrp_key_match.sv */
`timescale 1ns / 1ps

module kvrp_key_match #(
  parameter int unsigned TABLE_ENTRIES = 15,
  parameter int unsigned MAX_NAME_LEN  = 12,
  parameter int unsigned KEY_LEN_W     = 4
) (
  input  logic [7:0]               char_i,
  input  logic [KEY_LEN_W-1:0]     key_len_i,
  input  logic [TABLE_ENTRIES-1:0] alive_i,
  input  logic [TABLE_ENTRIES-1:0] done_i,
  output logic [TABLE_ENTRIES-1:0] alive_o,
  output logic [TABLE_ENTRIES-1:0] done_o
);

  // Compare one key character against every entry in parallel
  always_comb begin
    logic [4:0] len;
    logic [4:0] slot;
    logic [3:0] pos;
    alive_o = alive_i;
    done_o  = done_i;
    pos     = 4'(key_len_i);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot = 5'(i);
      len  = kvrp_pkg::ROM_LEN[slot];
      if (len != 5'd0 && 32'(len) <= MAX_NAME_LEN && 6'(key_len_i) < 6'(len)) begin
        if (kvrp_pkg::rom_char(slot, pos) != char_i) begin
          alive_o[i] = 1'b0;
        end else if (6'(key_len_i) == 6'(len) - 6'd1 && alive_i[i]) begin
          done_o[i] = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/kvrp_value_conv.sv */
`timescale 1ns / 1ps

module kvrp_value_conv (
  input  logic [7:0]             char_i,
  input  kvrp_pkg::num_state_t   state_i,
  output kvrp_pkg::num_state_t   state_o
);

  always_comb begin
    logic is_space;
    logic is_sign;
    logic is_digit;
    logic take_digit;
    is_space = (char_i == kvrp_pkg::CH_SP) || (char_i == kvrp_pkg::CH_TAB) ||
               (char_i == kvrp_pkg::CH_VT) || (char_i == kvrp_pkg::CH_FF) ||
               (char_i == kvrp_pkg::CH_CR);
    is_sign  = (char_i == kvrp_pkg::CH_PLUS) || (char_i == kvrp_pkg::CH_MINUS);
    is_digit = (char_i >= kvrp_pkg::CH_0) && (char_i <= kvrp_pkg::CH_9);
    state_o    = state_i;
    take_digit = 1'b0;

    case (state_i.phase)
      kvrp_pkg::NUM_SKIP: begin
        if (is_space) begin
          take_digit = 1'b0;
        end else if (is_sign) begin
          state_o.negative = (char_i == kvrp_pkg::CH_MINUS);
          state_o.phase    = kvrp_pkg::NUM_DIGITS;
        end else begin
          state_o.phase = kvrp_pkg::NUM_DIGITS;
          take_digit    = 1'b1;
        end
      end
      kvrp_pkg::NUM_DIGITS: take_digit = 1'b1;
      default:              take_digit = 1'b0;
    endcase

    // acc * 10 + digit, wrapping at 32 bits
    if (take_digit) begin
      if (is_digit) begin
        state_o.acc = (state_i.acc << 3) + (state_i.acc << 1) +
                      32'(char_i - kvrp_pkg::CH_0);
      end else begin
        state_o.phase = kvrp_pkg::NUM_STOP;
      end
    end
  end

endmodule

/* rtl/key_value_record_parser.sv */
`timescale 1ns / 1ps
// Words wait in the input register; a finished record loads the result register.
// Throughput: one word per cycle unless the result stalls, which only holds input;
// the input register, parallel name compare and result register set that rate.
// Reset: rst_ni clears all record state and the valid bits of the input and result
// registers asynchronously; the block accepts words from the first edge after it.
module key_value_record_parser #(
  parameter int unsigned TABLE_ENTRIES = 15,
  parameter int unsigned MAX_NAME_LEN  = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  kvrp_in_if.sink         in_i,
  kvrp_out_if.source      out_o
);

  localparam int unsigned KEY_LEN_W = $clog2(MAX_NAME_LEN + 1);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register
  logic                             out_valid_q;
  logic [kvrp_pkg::ID_W-1:0]        out_id_q;
  logic [kvrp_pkg::VALUE_W-1:0]     out_value_q;

  // Record state
  logic                       in_value_q, in_value_d;
  logic [KEY_LEN_W-1:0]       key_len_q, key_len_d;
  logic [TABLE_ENTRIES-1:0]   alive_q, alive_d;
  logic [TABLE_ENTRIES-1:0]   done_q, done_d;
  logic                       value_nz_q, value_nz_d;
  kvrp_pkg::num_state_t       num_q, num_d;

  logic                       advance;
  logic                       out_free;
  logic                       has_result;
  logic [TABLE_ENTRIES-1:0]   alive_next;
  logic [TABLE_ENTRIES-1:0]   done_next;
  kvrp_pkg::num_state_t       num_next;
  logic                       hit;
  logic [4:0]                 hit_idx;
  logic [kvrp_pkg::ID_W-1:0]  result_id;
  logic [kvrp_pkg::VALUE_W-1:0] result_value;

  // A word leaves the input register whenever the result register has room
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  kvrp_key_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .KEY_LEN_W     (KEY_LEN_W)
  ) u_key_match (
    .char_i    (in_byte_q),
    .key_len_i (key_len_q),
    .alive_i   (alive_q),
    .done_i    (done_q),
    .alive_o   (alive_next),
    .done_o    (done_next)
  );

  kvrp_value_conv u_value_conv (
    .char_i  (in_byte_q),
    .state_i (num_q),
    .state_o (num_next)
  );

  // First completed entry wins: scan from the top so the lowest index ends up
  always_comb begin
    hit     = 1'b0;
    hit_idx = 5'd0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (done_q[i]) begin
        hit     = 1'b1;
        hit_idx = 5'(i);
      end
    end
  end

  assign result_id    = kvrp_pkg::ID_W'(6'(hit_idx) + 6'(kvrp_pkg::ID_OFFSET));
  assign result_value = num_q.negative ? (32'd0 - num_q.acc) : num_q.acc;

  // Per-word record control
  always_comb begin
    logic is_eol;
    logic clear;
    is_eol     = (in_byte_q == kvrp_pkg::CH_NUL) || (in_byte_q == kvrp_pkg::CH_LF);
    clear      = 1'b0;
    has_result = 1'b0;
    in_value_d = in_value_q;
    key_len_d  = key_len_q;
    alive_d    = alive_q;
    done_d     = done_q;
    value_nz_d = value_nz_q;
    num_d      = num_q;

    if (is_eol) begin
      // End of line: finish an open value, drop an unfinished key
      has_result = in_value_q && value_nz_q && hit;
      clear      = 1'b1;
    end else if (!in_value_q) begin
      if (in_byte_q == kvrp_pkg::CH_EQ) begin
        if (key_len_q == '0) begin
          clear = 1'b1;
        end else begin
          in_value_d = 1'b1;
        end
      end else begin
        alive_d = alive_next;
        done_d  = done_next;
        if (key_len_q < KEY_LEN_W'(MAX_NAME_LEN)) begin
          key_len_d = key_len_q + KEY_LEN_W'(1);
        end
      end
    end else if (in_byte_q == kvrp_pkg::CH_COLON) begin
      has_result = value_nz_q && hit;
      clear      = 1'b1;
    end else begin
      value_nz_d = 1'b1;
      num_d      = num_next;
    end

    if (clear) begin
      in_value_d     = 1'b0;
      key_len_d      = '0;
      alive_d        = '1;
      done_d         = '0;
      value_nz_d     = 1'b0;
      num_d.phase    = kvrp_pkg::NUM_SKIP;
      num_d.negative = 1'b0;
      num_d.acc      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q     <= 1'b0;
      key_len_q      <= '0;
      alive_q        <= '1;
      done_q         <= '0;
      value_nz_q     <= 1'b0;
      num_q.phase    <= kvrp_pkg::NUM_SKIP;
      num_q.negative <= 1'b0;
      num_q.acc      <= '0;
    end else if (advance) begin
      in_value_q <= in_value_d;
      key_len_q  <= key_len_d;
      alive_q    <= alive_d;
      done_q     <= done_d;
      value_nz_q <= value_nz_d;
      num_q      <= num_d;
    end
  end

  // Result register: load on a finished record, hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_id_q    <= result_id;
      out_value_q <= result_value;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.param_id    = out_id_q;
  assign out_o.param_value = out_value_q;

endmodule
